[src/mlp_pkg.sv]
// Shared types and constants for the message length padder.
package mlp_pkg;

    // Input operation codes
    localparam logic OP_DATA = 1'b0;
    localparam logic OP_END  = 1'b1;

    // Block size limits and reset value
    localparam logic [7:0] BLOCK_RESET     = 8'd64;
    localparam logic [7:0] MIN_BLOCK_BYTES = 8'd16;
    localparam logic [7:0] MAX_BLOCK_BYTES = 8'd128;

    // Padding bytes
    localparam logic [7:0] PAD_MARK = 8'h80;
    localparam logic [7:0] PAD_ZERO = 8'h00;

    // Bytes per output chunk
    localparam logic [7:0] CHUNK_BYTES = 8'd8;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_REM,
        ST_PAD
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic data_push;   // pass a data byte through, bump counters
        logic end_start;   // latch remainder and bit length, clear counters
        logic rem_sub;     // one reduction step of the remainder
        logic pad_init;    // compute padding length
        logic chunk_emit;  // load one padding chunk into the output register
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic out_free;    // output register can take a new item this cycle
        logic rem_ge_bb;   // remainder still at or above the block size
        logic last_chunk;  // current chunk is the final padding chunk
    } t_dp_stat;

endpackage

[src/mlp_ctrl.sv]
// Controller state machine for the message length padder.
module mlp_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_opcode,
    input  mlp_pkg::t_dp_stat i_stat,
    output logic              o_in_ready,
    output mlp_pkg::t_dp_cmd  o_cmd
);
    import mlp_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = i_stat.out_free;
                if (i_in_valid && i_stat.out_free) begin
                    if (i_opcode == OP_END) begin
                        o_cmd.end_start = 1'b1;
                        n_state         = ST_REM;
                    end else begin
                        o_cmd.data_push = 1'b1;
                    end
                end
            end
            ST_REM: begin
                if (i_stat.rem_ge_bb) begin
                    o_cmd.rem_sub = 1'b1;
                end else begin
                    o_cmd.pad_init = 1'b1;
                    n_state        = ST_PAD;
                end
            end
            ST_PAD: begin
                if (i_stat.out_free) begin
                    o_cmd.chunk_emit = 1'b1;
                    if (i_stat.last_chunk) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

[src/mlp_dp.sv]
// Datapath for the message length padder: counters, padding builder, output register.
module mlp_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    input  logic [7:0]        i_cfg_data,
    input  logic [7:0]        i_data_byte,
    input  logic              i_out_ready,
    input  mlp_pkg::t_dp_cmd  i_cmd,
    output mlp_pkg::t_dp_stat o_stat,
    output logic              o_out_valid,
    output logic [63:0]       o_out_chunk,
    output logic [3:0]        o_byte_count,
    output logic              o_last
);
    import mlp_pkg::*;

    logic [7:0]  r_block_bytes;
    logic [6:0]  r_block_pos;
    logic [60:0] r_msg_bytes;
    logic [6:0]  r_rem;
    logic [7:0]  r_pad;
    logic [7:0]  r_offset;
    logic [63:0] r_bits;
    logic        r_out_valid;
    logic [63:0] r_out_chunk;
    logic [3:0]  r_out_count;
    logic        r_out_last;

    logic [7:0]  eff_bb;
    logic [6:0]  pos_inc;
    logic [7:0]  pad_raw;
    logic [7:0]  pad_left;
    logic [7:0]  len_start;
    logic [8:0]  offset_end;
    logic [63:0] chunk;
    logic [3:0]  count;

    // Clamp the block size to its legal range
    always_comb begin
        eff_bb = r_block_bytes;
        if (r_block_bytes < MIN_BLOCK_BYTES) eff_bb = MIN_BLOCK_BYTES;
        if (r_block_bytes > MAX_BLOCK_BYTES) eff_bb = MAX_BLOCK_BYTES;
    end

    assign pos_inc    = r_block_pos + 7'd1;
    assign pad_raw    = eff_bb - {1'b0, r_rem};
    assign pad_left   = r_pad - r_offset;
    assign len_start  = r_pad - CHUNK_BYTES;
    assign offset_end = {1'b0, r_offset} + {1'b0, CHUNK_BYTES};

    // Build one padding chunk: marker, zeros, big-endian bit length
    always_comb begin
        logic [7:0] p;
        logic [7:0] k;
        logic [2:0] sel;
        logic [7:0] b;
        chunk = '0;
        for (int j = 0; j < 8; j++) begin
            p   = r_offset + 8'(j);
            k   = p - len_start;
            sel = 3'd7 - k[2:0];
            b   = PAD_ZERO;
            if (p == 8'd0) begin
                b = PAD_MARK;
            end else if (p >= len_start) begin
                b = r_bits[{sel, 3'b000} +: 8];
            end
            if (p < r_pad) begin
                chunk[(7 - j) * 8 +: 8] = b;
            end
        end
        count = (pad_left >= CHUNK_BYTES) ? 4'd8 : pad_left[3:0];
    end

    // Status to the controller
    assign o_stat.out_free   = !r_out_valid || i_out_ready;
    assign o_stat.rem_ge_bb  = {1'b0, r_rem} >= eff_bb;
    assign o_stat.last_chunk = offset_end >= {1'b0, r_pad};

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_bytes <= BLOCK_RESET;
        end else if (i_cfg_valid) begin
            r_block_bytes <= i_cfg_data;
        end
    end

    // Message counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_pos <= '0;
            r_msg_bytes <= '0;
        end else if (i_cmd.data_push) begin
            r_msg_bytes <= r_msg_bytes + 61'd1;
            r_block_pos <= ({1'b0, pos_inc} >= eff_bb) ? 7'd0 : pos_inc;
        end else if (i_cmd.end_start) begin
            r_block_pos <= '0;
            r_msg_bytes <= '0;
        end
    end

    // Padding working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.end_start) begin
            r_rem  <= r_block_pos;
            r_bits <= {r_msg_bytes, 3'b000};
        end else if (i_cmd.rem_sub) begin
            r_rem <= r_rem - eff_bb[6:0];
        end
        if (i_cmd.pad_init) begin
            r_pad    <= (pad_raw <= CHUNK_BYTES) ? pad_raw + eff_bb : pad_raw;
            r_offset <= '0;
        end else if (i_cmd.chunk_emit) begin
            r_offset <= offset_end[7:0];
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.data_push || i_cmd.chunk_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.data_push) begin
            r_out_chunk <= {i_data_byte, 56'd0};
            r_out_count <= 4'd1;
            r_out_last  <= 1'b0;
        end else if (i_cmd.chunk_emit) begin
            r_out_chunk <= chunk;
            r_out_count <= count;
            r_out_last  <= o_stat.last_chunk;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_chunk  = r_out_chunk;
    assign o_byte_count = r_out_count;
    assign o_last       = r_out_last;

endmodule

[src/message_length_padder_top.sv]
// A result is in the output register in the cycle after its item is accepted.
// Throughput: data items stream at one per cycle through the output register while the output port is ready.
// An end item is accepted, the remainder is reduced by repeated subtraction of the
// block size, the padding length is set up, then the padding chunks go out as the output port allows.
// Reset (synchronous, active low) clears the counters, the controller and the
// output valid, and sets the block size to 64.
module message_length_padder_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_opcode,
    input  logic [7:0]  i_data_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [63:0] o_out_chunk,
    output logic [3:0]  o_byte_count,
    output logic        o_last
);
    import mlp_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    assign o_cfg_ready = 1'b1;

    // Controller
    mlp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_opcode   (i_opcode),
        .i_stat     (stat),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    // Datapath
    mlp_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_data   (i_cfg_data),
        .i_data_byte  (i_data_byte),
        .i_out_ready  (i_out_ready),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .o_out_valid  (o_out_valid),
        .o_out_chunk  (o_out_chunk),
        .o_byte_count (o_byte_count),
        .o_last       (o_last)
    );

endmodule

[tb/sv/message_length_padder_top_test.sv]
// Self-checking testbench for the message length padder: random handshakes, predicted chunks.
`timescale 1ns / 100ps

module message_length_padder_top_test;
    import mlp_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 300000;

    typedef struct {
        logic       op;
        logic [7:0] data;
    } t_msg_item;

    typedef struct {
        logic [63:0] chunk;
        logic [3:0]  count;
        logic        last;
    } t_pad_chunk;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic [7:0]  i_cfg_data = 8'd0;
    logic        i_in_valid = 1'b0;
    logic        i_opcode = OP_DATA;
    logic [7:0]  i_data_byte = 8'd0;
    logic        i_out_ready = 1'b0;
    logic        o_cfg_ready;
    logic        o_in_ready;
    logic        o_out_valid;
    logic [63:0] o_out_chunk;
    logic [3:0]  o_byte_count;
    logic        o_last;

    // Items waiting to be offered, chunks waiting to come out
    t_msg_item   pending_items[$];
    t_pad_chunk  expected_chunks[$];

    // Predictor state: block size register, position in block, message length
    logic [7:0]  cfg_block = BLOCK_RESET;
    logic [6:0]  block_pos = '0;
    logic [60:0] msg_len = '0;

    int unsigned n_err = 0;
    int unsigned n_got = 0;
    int unsigned cycles = 0;
    int unsigned send_gap = 0;
    int unsigned hold_cnt = 0;
    bit          long_hold_done = 1'b0;
    bit          calm = 1'b0;

    message_length_padder_top dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_opcode     (i_opcode),
        .i_data_byte  (i_data_byte),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_chunk  (o_out_chunk),
        .o_byte_count (o_byte_count),
        .o_last       (o_last)
    );

    // 2 ns clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Block size after clamping to the supported range
    function automatic int unsigned eff_block(input logic [7:0] blk);
        if (blk < MIN_BLOCK_BYTES) return 32'(MIN_BLOCK_BYTES);
        if (blk > MAX_BLOCK_BYTES) return 32'(MAX_BLOCK_BYTES);
        return 32'(blk);
    endfunction

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    // Expected chunks for one accepted item; updates the length counters
    task automatic absorb_item(input logic op, input logic [7:0] din);
        int unsigned bb, cb, pad, len_start, n, p, i, j;
        logic [63:0] bits, word;
        logic [7:0]  b;
        bb = eff_block(cfg_block);
        cb = 32'(CHUNK_BYTES);
        if (op == OP_DATA) begin
            expected_chunks.insert(expected_chunks.size(),
                                   t_pad_chunk'{{din, 56'h0}, 4'd1, 1'b0});
            msg_len = msg_len + 61'd1;
            block_pos = block_pos + 7'd1;
            if (32'(block_pos) >= bb) block_pos = '0;
        end else begin
            pad = bb - (32'(block_pos) % bb);
            if (pad <= cb) pad += bb;
            len_start = pad - cb;
            bits = {msg_len, 3'b000};
            for (i = 0; i < pad; i += cb) begin
                n = (pad - i > cb) ? cb : pad - i;
                word = '0;
                for (j = 0; j < n; j++) begin
                    p = i + j;
                    if (p == 0) b = PAD_MARK;
                    else if (p >= len_start) b = bits[8 * (7 - (p - len_start)) +: 8];
                    else b = PAD_ZERO;
                    word[8 * (7 - j) +: 8] = b;
                end
                expected_chunks.insert(expected_chunks.size(),
                                       t_pad_chunk'{word, n[3:0], (i + cb >= pad)});
            end
            block_pos = '0;
            msg_len = '0;
        end
    endtask

    function automatic void queue_item(input logic op, input logic [7:0] d);
        pending_items.insert(pending_items.size(), t_msg_item'{op, d});
    endfunction

    // Wait until the sender is drained and every chunk has come out
    task automatic settle();
        do @(negedge i_clk);
        while (pending_items.size() != 0 || i_in_valid || expected_chunks.size() != 0);
    endtask

    task automatic write_block_size(input logic [7:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= val;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        cfg_block = val;
        i_cfg_valid <= 1'b0;
    endtask

    // One block size, a run of messages with random lengths and bytes
    task automatic run_random_phase(input logic [7:0] blk, input int unsigned quota,
                                    input bit with_long);
        int unsigned bb, sent, len, roll;
        bb = eff_block(blk);
        write_block_size(blk);
        sent = 0;
        // remainder of bb-8 forces an extra block: the longest padding
        if (with_long) begin
            repeat (bb - 8) queue_item(OP_DATA, rand_byte());
            queue_item(OP_END, rand_byte());
        end
        while (sent < quota) begin
            roll = $urandom_range(0, 19);
            if (roll < 12) len = $urandom_range(0, 12);
            else if (roll < 17) len = (bb <= 40) ? $urandom_range(bb - 10, bb - 6)
                                                 : $urandom_range(0, 30);
            else len = $urandom_range(13, 40);
            repeat (len) queue_item(OP_DATA, rand_byte());
            sent += len;
            // sometimes carry an open message over the next block size change
            if (sent >= quota && $urandom_range(0, 1) == 1) break;
            queue_item(OP_END, rand_byte());
            sent++;
        end
        settle();
    endtask

    // Input driver
    always @(posedge i_clk) begin : drive_items
        t_msg_item it;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) absorb_item(i_opcode, i_data_byte);
            if (!i_in_valid || o_in_ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_in_valid <= 1'b0;
                end else if (pending_items.size() != 0 && !calm
                             && $urandom_range(0, 7) == 0) begin
                    send_gap = $urandom_range(0, 9);
                    i_in_valid <= 1'b0;
                end else if (pending_items.size() != 0) begin
                    it = pending_items[0];
                    pending_items.delete(0);
                    i_opcode <= it.op;
                    i_data_byte <= it.data;
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Output monitor and receiver stalls
    always @(posedge i_clk) begin : watch_chunks
        t_pad_chunk e;
        logic       rdy;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                n_got++;
                if (expected_chunks.size() == 0) begin
                    $error("unexpected item: out_chunk %h byte_count %0d last %0d",
                           o_out_chunk, o_byte_count, o_last);
                    n_err++;
                end else begin
                    e = expected_chunks[0];
                    expected_chunks.delete(0);
                    if (o_out_chunk !== e.chunk) begin
                        $error("out_chunk: expected %h, got %h", e.chunk, o_out_chunk);
                        n_err++;
                    end
                    if (o_byte_count !== e.count) begin
                        $error("byte_count: expected %0d, got %0d", e.count, o_byte_count);
                        n_err++;
                    end
                    if (o_last !== e.last) begin
                        $error("last: expected %0d, got %0d", e.last, o_last);
                        n_err++;
                    end
                end
            end
            // long hold once, while the sender keeps offering, to back up the block
            if (hold_cnt > 0) begin
                hold_cnt--;
                rdy = 1'b0;
            end else if (!long_hold_done && n_got >= 100 && i_in_valid) begin
                hold_cnt = 79;
                long_hold_done = 1'b1;
                rdy = 1'b0;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                hold_cnt = $urandom_range(0, 9);
                rdy = 1'b0;
            end else begin
                rdy = 1'b1;
            end
            i_out_ready <= rdy;
        end
    end

    // Run limit
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("message_length_padder_top_test: FAIL");
            $finish;
        end
    end

    // Stimulus sequence
    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty message at the reset block size, then a two byte message
        queue_item(OP_END, 8'h5a);
        queue_item(OP_DATA, 8'hff);
        queue_item(OP_DATA, 8'h00);
        queue_item(OP_END, 8'ha5);
        settle();

        // zero clamps to the minimum block; padding just fits, then spills a block
        write_block_size(8'd0);
        repeat (7) queue_item(OP_DATA, rand_byte());
        queue_item(OP_END, 8'hff);
        repeat (8) queue_item(OP_DATA, rand_byte());
        queue_item(OP_END, 8'h00);
        settle();

        // oversize value clamps to the maximum block
        write_block_size(8'd200);
        queue_item(OP_DATA, 8'h3c);
        queue_item(OP_END, 8'hc3);
        settle();

        run_random_phase(8'd16, 9, 1'b1);
        run_random_phase(8'd128, 9, 1'b0);
        run_random_phase(8'd15, 9, 1'b0);
        run_random_phase(8'd255, 9, 1'b0);
        run_random_phase(8'($urandom_range(17, 127)), 9, 1'b0);
        run_random_phase(rand_byte(), 9, 1'b0);
        calm = 1'b1;
        run_random_phase(BLOCK_RESET, 9, 1'b0);

        repeat (20) @(posedge i_clk);
        if (n_err == 0) begin
            $display("message_length_padder_top_test: PASS");
        end else begin
            $display("message_length_padder_top_test: FAIL");
        end
        $finish;
    end

endmodule
